### hw/rtl/lsrc_pkg.sv
// ---------------------------------------------------------------------------
// lsrc_pkg: shared codes of the line segment clipper
// Register indexes and the per-edge action codes passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package lsrc_pkg;

    localparam int unsigned REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_CLIP_X = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_CLIP_Y = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_CLIP_W = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CLIP_H = 3'd3;

    // what the back end still has to do for one rectangle edge
    typedef enum logic [1:0] {
        EDGE_SKIP,
        EDGE_ENTER,
        EDGE_LEAVE
    } edge_act_t;

endpackage

`default_nettype wire

### hw/rtl/lsrc_front.sv
// ---------------------------------------------------------------------------
// lsrc_front: configuration and classification
// Holds the clip rectangle, sorts each segment into trivial cases and the
// general case, and prepares the edge ratios for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module lsrc_front #(
    parameter int W = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lsrc_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  wire logic [W-1:0]                    cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [W-1:0]             x_start,
    input  wire logic signed [W-1:0]             y_start,
    input  wire logic signed [W-1:0]             x_end,
    input  wire logic signed [W-1:0]             y_end,
    output logic                                 fq_valid,
    input  wire logic                            fq_ready,
    output logic [14*W+11:0]                     fq_data
);

    typedef struct packed {
        logic                             gen;
        logic                             vis;
        logic [W-1:0]                     cx0;
        logic [W-1:0]                     cy0;
        logic [W-1:0]                     cx1;
        logic [W-1:0]                     cy1;
        logic                             sgx;
        logic                             sgy;
        logic [W-1:0]                     magx;
        logic [W-1:0]                     magy;
        lsrc_pkg::edge_act_t [3:0]        act;
        logic [3:0][W-1:0]                num;
        logic [3:0][W-1:0]                den;
    } fq_t;

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

    logic signed [W-1:0] clip_x_reg, clip_y_reg, clip_w_reg, clip_h_reg;
    logic                v_reg;
    fq_t                 item_reg;
    fq_t                 item_next;

    logic signed [W:0]   ex2w, ey2w, dx, dy, ndx, ndy;
    logic signed [W-1:0] ex1, ey1, ex2, ey2;
    logic signed [W:0]   q [4];
    logic signed [W:0]   sn;
    logic [3:0]          pneg;
    logic [3:0]          rej;
    logic                empty, outside;

    function automatic logic signed [W-1:0] clampc(input logic signed [W-1:0] v,
                                                   input logic signed [W-1:0] lo,
                                                   input logic signed [W-1:0] hi);
        logic signed [W-1:0] r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_reg <= '0;
            clip_y_reg <= '0;
            clip_w_reg <= '0;
            clip_h_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsrc_pkg::REG_CLIP_X: clip_x_reg <= cfg_data;
                lsrc_pkg::REG_CLIP_Y: clip_y_reg <= cfg_data;
                lsrc_pkg::REG_CLIP_W: clip_w_reg <= cfg_data;
                lsrc_pkg::REG_CLIP_H: clip_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ex1  = clip_x_reg;
        ey1  = clip_y_reg;
        ex2w = {clip_x_reg[W-1], clip_x_reg} + {clip_w_reg[W-1], clip_w_reg} - (W+1)'(1);
        ey2w = {clip_y_reg[W-1], clip_y_reg} + {clip_h_reg[W-1], clip_h_reg} - (W+1)'(1);
        // far edges may run past the coordinate range
        ex2  = (ex2w > $signed({1'b0, CMAX})) ? CMAX : ex2w[W-1:0];
        ey2  = (ey2w > $signed({1'b0, CMAX})) ? CMAX : ey2w[W-1:0];

        empty   = (clip_w_reg <= 0) || (clip_h_reg <= 0);
        outside = (x_start < ex1 && x_end < ex1) || (x_start > ex2 && x_end > ex2) ||
                  (y_start < ey1 && y_end < ey1) || (y_start > ey2 && y_end > ey2);

        dx  = {x_end[W-1], x_end} - {x_start[W-1], x_start};
        dy  = {y_end[W-1], y_end} - {y_start[W-1], y_start};
        ndx = -dx;
        ndy = -dy;

        q[0] = {x_start[W-1], x_start} - {ex1[W-1], ex1};
        q[1] = {ex2[W-1], ex2} - {x_start[W-1], x_start};
        q[2] = {y_start[W-1], y_start} - {ey1[W-1], ey1};
        q[3] = {ey2[W-1], ey2} - {y_start[W-1], y_start};
        pneg[0] = !dx[W];
        pneg[1] = dx[W];
        pneg[2] = !dy[W];
        pneg[3] = dy[W];

        item_next      = '0;
        item_next.cx0  = x_start;
        item_next.cy0  = y_start;
        item_next.cx1  = x_end;
        item_next.cy1  = y_end;
        item_next.sgx  = dx[W];
        item_next.sgy  = dy[W];
        item_next.magx = dx[W] ? ndx[W-1:0] : dx[W-1:0];
        item_next.magy = dy[W] ? ndy[W-1:0] : dy[W-1:0];

        for (int k = 0; k < 4; k++)
        begin
            item_next.den[k] = (k < 2) ? item_next.magx : item_next.magy;
            sn               = pneg[k] ? -q[k] : q[k];
            item_next.num[k] = sn[W-1:0];
            rej[k]           = 1'b0;
            item_next.act[k] = lsrc_pkg::EDGE_SKIP;
            if (pneg[k])
            begin
                if (!sn[W])
                begin
                    if (sn[W-1:0] > item_next.den[k])
                    begin
                        rej[k] = 1'b1;
                    end
                    else
                    begin
                        item_next.act[k] = lsrc_pkg::EDGE_ENTER;
                    end
                end
            end
            else
            begin
                if (sn[W])
                begin
                    rej[k] = 1'b1;
                end
                else if (sn[W-1:0] <= item_next.den[k])
                begin
                    item_next.act[k] = lsrc_pkg::EDGE_LEAVE;
                end
            end
        end

        if (!empty && !outside)
        begin
            if (y_start == y_end)
            begin
                item_next.vis = 1'b1;
                item_next.cx0 = clampc(x_start, ex1, ex2);
                item_next.cx1 = clampc(x_end, ex1, ex2);
            end
            else if (x_start == x_end)
            begin
                item_next.vis = 1'b1;
                item_next.cy0 = clampc(y_start, ey1, ey2);
                item_next.cy1 = clampc(y_end, ey1, ey2);
            end
            else
            begin
                item_next.gen = ~|rej;
            end
        end
    end

    assign in_ready = !v_reg || fq_ready;
    assign fq_valid = v_reg;
    assign fq_data  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            v_reg <= 1'b1;
        end
        else if (fq_ready)
        begin
            v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lsrc_fifo.sv
// ---------------------------------------------------------------------------
// lsrc_fifo: short queue between front and back
// Four entries, so either side can stall without holding the other.
// ---------------------------------------------------------------------------
`default_nettype none

module lsrc_fifo #(
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire logic [DW-1:0] wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output logic [DW-1:0]      rd_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lsrc_div.sv
// ---------------------------------------------------------------------------
// lsrc_div: pipelined restoring divider
// One quotient bit per stage; the quotient is known to fit in W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module lsrc_div #(
    parameter int W = 16
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [2*W-1:0] n,
    input  wire logic [W-1:0]   d,
    output logic [W-1:0]        q
);

    logic [W-1:0] r_reg  [W];
    logic [W-1:0] lo_reg [W];
    logic [W-1:0] q_reg  [W];
    logic [W-1:0] d_reg  [W];

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic [W-1:0] r_in, lo_in, q_in, d_in;
        logic [W:0]   t, t2;
        logic         ge;

        if (i == 0)
        begin : g_first
            assign r_in  = n[2*W-1:W];
            assign lo_in = n[W-1:0];
            assign q_in  = '0;
            assign d_in  = d;
        end
        else
        begin : g_next
            assign r_in  = r_reg[i-1];
            assign lo_in = lo_reg[i-1];
            assign q_in  = q_reg[i-1];
            assign d_in  = d_reg[i-1];
        end

        assign t  = {r_in, lo_in[W-1]};
        assign ge = t >= {1'b0, d_in};
        assign t2 = t - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]  <= ge ? t2[W-1:0] : t[W-1:0];
                lo_reg[i] <= {lo_in[W-2:0], 1'b0};
                q_reg[i]  <= {q_in[W-2:0], ge};
                d_reg[i]  <= d_in;
            end
        end
    end

    assign q = q_reg[W-1];

endmodule

`default_nettype wire

### hw/rtl/lsrc_back.sv
// ---------------------------------------------------------------------------
// lsrc_back: clip execution pipeline
// Edge steps, one per rectangle edge, with cross-multiplied ratio compares, then the endpoint
// products, the dividers and the final add into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lsrc_back #(
    parameter int W = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fq_valid,
    output logic                     fq_ready,
    input  wire logic [14*W+11:0]    fq_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     visible,
    output logic signed [W-1:0]      clipped_x_start,
    output logic signed [W-1:0]      clipped_y_start,
    output logic signed [W-1:0]      clipped_x_end,
    output logic signed [W-1:0]      clipped_y_end
);

    typedef struct packed {
        logic                             gen;
        logic                             vis;
        logic [W-1:0]                     cx0;
        logic [W-1:0]                     cy0;
        logic [W-1:0]                     cx1;
        logic [W-1:0]                     cy1;
        logic                             sgx;
        logic                             sgy;
        logic [W-1:0]                     magx;
        logic [W-1:0]                     magy;
        lsrc_pkg::edge_act_t [3:0]        act;
        logic [3:0][W-1:0]                num;
        logic [3:0][W-1:0]                den;
    } fq_t;

    typedef struct packed {
        fq_t          f;
        logic [W-1:0] n0;
        logic [W-1:0] d0;
        logic [W-1:0] n1;
        logic [W-1:0] d1;
    } bk_t;

    localparam int NS = 9;

    bk_t            st_reg [NS+1];
    logic [NS:0]    v_reg;
    logic [2*W-1:0] pa_reg [4];
    logic [2*W-1:0] pb_reg [4];
    logic [2*W-1:0] pc_reg [4];
    logic [2*W-1:0] pd_reg [4];
    logic [2*W-1:0] m_reg  [4];
    bk_t            sd_reg [W];
    logic [W-1:0]   vd_reg;
    logic [W-1:0]   qv [4];
    logic           en;
    logic           vo_reg;

    assign en       = !vo_reg || out_ready;
    assign fq_ready = en;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= {fq_t'(fq_data), W'(0), W'(1), W'(1), W'(1)};
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_edge
        bk_t  cur, upd;
        logic gt1, gt0, lt1, lt0;

        assign cur = st_reg[2*k+1];
        assign gt1 = pa_reg[k] > pb_reg[k];
        assign lt1 = pa_reg[k] < pb_reg[k];
        assign gt0 = pc_reg[k] > pd_reg[k];
        assign lt0 = pc_reg[k] < pd_reg[k];

        always_comb
        begin
            upd = cur;
            if (cur.f.gen)
            begin
                case (cur.f.act[k])
                    lsrc_pkg::EDGE_ENTER:
                    begin
                        if (gt1)
                        begin
                            upd.f.gen = 1'b0;
                        end
                        else if (gt0)
                        begin
                            upd.n0 = cur.f.num[k];
                            upd.d0 = cur.f.den[k];
                        end
                    end
                    lsrc_pkg::EDGE_LEAVE:
                    begin
                        if (lt0)
                        begin
                            upd.f.gen = 1'b0;
                        end
                        else if (lt1)
                        begin
                            upd.n1 = cur.f.num[k];
                            upd.d1 = cur.f.den[k];
                        end
                    end
                    default: ;
                endcase
            end
        end

        // ratio products are registered first; the compare and update use them in the next register stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[2*k+1] <= st_reg[2*k];
                pa_reg[k] <= st_reg[2*k].f.num[k] * st_reg[2*k].d1;
                pb_reg[k] <= st_reg[2*k].n1 * st_reg[2*k].f.den[k];
                pc_reg[k] <= st_reg[2*k].f.num[k] * st_reg[2*k].d0;
                pd_reg[k] <= st_reg[2*k].n0 * st_reg[2*k].f.den[k];
                st_reg[2*k+2] <= upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[NS] <= st_reg[NS-1];
            m_reg[0]   <= st_reg[NS-1].n0 * st_reg[NS-1].f.magx;
            m_reg[1]   <= st_reg[NS-1].n0 * st_reg[NS-1].f.magy;
            m_reg[2]   <= st_reg[NS-1].n1 * st_reg[NS-1].f.magx;
            m_reg[3]   <= st_reg[NS-1].n1 * st_reg[NS-1].f.magy;
            sd_reg[0]  <= st_reg[NS];
            for (int i = 1; i < W; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_div
        lsrc_div #(.W(W)) u_div (
            .clk (clk),
            .en  (en),
            .n   (m_reg[j]),
            .d   ((j < 2) ? st_reg[NS].d0 : st_reg[NS].d1),
            .q   (qv[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vd_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[NS-1:0], fq_valid};
            vd_reg <= {vd_reg[W-2:0], v_reg[NS]};
            vo_reg <= vd_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sd_reg[W-1].f.gen)
            begin
                visible         <= 1'b1;
                clipped_x_start <= sd_reg[W-1].f.sgx ? sd_reg[W-1].f.cx0 - qv[0]
                                                     : sd_reg[W-1].f.cx0 + qv[0];
                clipped_y_start <= sd_reg[W-1].f.sgy ? sd_reg[W-1].f.cy0 - qv[1]
                                                     : sd_reg[W-1].f.cy0 + qv[1];
                clipped_x_end   <= sd_reg[W-1].f.sgx ? sd_reg[W-1].f.cx0 - qv[2]
                                                     : sd_reg[W-1].f.cx0 + qv[2];
                clipped_y_end   <= sd_reg[W-1].f.sgy ? sd_reg[W-1].f.cy0 - qv[3]
                                                     : sd_reg[W-1].f.cy0 + qv[3];
            end
            else
            begin
                visible         <= sd_reg[W-1].f.vis;
                clipped_x_start <= sd_reg[W-1].f.cx0;
                clipped_y_start <= sd_reg[W-1].f.cy0;
                clipped_x_end   <= sd_reg[W-1].f.cx1;
                clipped_y_end   <= sd_reg[W-1].f.cy1;
            end
        end
    end

    assign out_valid = vo_reg;

endmodule

`default_nettype wire

### hw/rtl/line_segment_rect_clipper.sv
// throughput: one segment per cycle while out_ready is not held low, set by the pipelined multipliers and dividers
// the four-entry queue between front and back absorbs stalls on either side
// reset: asynchronous active low, empties the pipeline and clears the rectangle to 0
// ---------------------------------------------------------------------------
// line_segment_rect_clipper: segment clipping against a pixel rectangle
// Front end classifies each segment, back end runs the exact-ratio clip.
// ---------------------------------------------------------------------------
`default_nettype none

module line_segment_rect_clipper #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lsrc_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]             cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      x_start,
    input  wire logic signed [COORD_BITS-1:0]      y_start,
    input  wire logic signed [COORD_BITS-1:0]      x_end,
    input  wire logic signed [COORD_BITS-1:0]      y_end,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   visible,
    output logic signed [COORD_BITS-1:0]           clipped_x_start,
    output logic signed [COORD_BITS-1:0]           clipped_y_start,
    output logic signed [COORD_BITS-1:0]           clipped_x_end,
    output logic signed [COORD_BITS-1:0]           clipped_y_end
);

    localparam int QW = 14*COORD_BITS + 12;

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [QW-1:0] f_data, b_data;

    lsrc_front #(.W(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .fq_valid  (f_valid),
        .fq_ready  (f_ready),
        .fq_data   (f_data)
    );

    lsrc_fifo #(.DW(QW)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    lsrc_back #(.W(COORD_BITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fq_valid        (b_valid),
        .fq_ready        (b_ready),
        .fq_data         (b_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .visible         (visible),
        .clipped_x_start (clipped_x_start),
        .clipped_y_start (clipped_y_start),
        .clipped_x_end   (clipped_x_end),
        .clipped_y_end   (clipped_y_end)
    );

endmodule

`default_nettype wire

### hw/rtl/lsrc_checker.sv
// ---------------------------------------------------------------------------
// lsrc_checker: port-level checks of the clipper
// Result handshake, reset behavior and input readiness after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module lsrc_checker #(
    parameter int COORD_BITS = 16
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  visible,
    input wire logic [COORD_BITS-1:0] clipped_x_start,
    input wire logic [COORD_BITS-1:0] clipped_x_end
);

    // a stalled result keeps its valid, its visible flag and its x coordinates
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(visible)
            && $stable(clipped_x_start) && $stable(clipped_x_end))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // input is ready right after reset
    a_reset_ready: assert property (@(posedge clk)
        $past(!rst_n) |-> in_ready)
        else $error("input not ready right after reset");

endmodule

bind line_segment_rect_clipper lsrc_checker #(.COORD_BITS(COORD_BITS)) u_lsrc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .visible         (visible),
    .clipped_x_start (clipped_x_start),
    .clipped_x_end   (clipped_x_end)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: line segment clipper testbench
// Directed rows and random segments against a local exact-ratio clip model,
// over several clip rectangles, with random idling on both handshakes.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CB = 16;
    localparam int LIMIT = 2000000;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } segment_t;

    typedef struct packed {
        logic   vis;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } clip_res_t;

    typedef struct packed {
        segment_t  seg;
        logic      typed;
        clip_res_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lsrc_pkg::REG_IDX_BITS-1:0] cfg_index;
    logic [CB-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    coord_t x_start, y_start, x_end, y_end;
    logic out_valid;
    logic out_ready;
    logic visible;
    coord_t clipped_x_start, clipped_y_start, clipped_x_end, clipped_y_end;

    line_segment_rect_clipper #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .visible(visible),
        .clipped_x_start(clipped_x_start), .clipped_y_start(clipped_y_start),
        .clipped_x_end(clipped_x_end), .clipped_y_end(clipped_y_end)
    );

    // local copy of the rectangle registers
    coord_t rect_x, rect_y, rect_w, rect_h;

    clip_res_t expected_clips[$];
    int  errors = 0;
    int  cycle = 0;
    bit  stim_done = 0;
    bit  hold_off = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // sign of a/b - c/d with positive denominators
    function automatic int ratio_cmp(longint a, longint b, longint c, longint d);
        longint l, r;
        l = a * d;
        r = c * b;
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    // one boundary test; updates the entry (n0/d0) and exit (n1/d1) ratios
    function automatic bit boundary(longint p, longint q, inout longint n0,
                                    inout longint d0, inout longint n1,
                                    inout longint d1);
        longint num, den, sn;
        if (p == 0) return q >= 0;
        den = p < 0 ? -p : p;
        sn = p < 0 ? -q : q;
        if (p < 0)
        begin
            if (sn < 0) return 1;
            num = sn;
            if (num > den) return 0;
            if (ratio_cmp(num, den, n1, d1) > 0) return 0;
            if (ratio_cmp(num, den, n0, d0) > 0)
            begin
                n0 = num;
                d0 = den;
            end
        end
        else
        begin
            if (sn < 0) return 0;
            num = sn;
            if (num > den) return 1;
            if (ratio_cmp(num, den, n0, d0) < 0) return 0;
            if (ratio_cmp(num, den, n1, d1) < 0)
            begin
                n1 = num;
                d1 = den;
            end
        end
        return 1;
    endfunction

    function automatic longint lerp_trunc(longint s, longint dl, longint n, longint d);
        longint mag, off;
        mag = dl < 0 ? -dl : dl;
        off = (n * mag) / d;
        return dl < 0 ? s - off : s + off;
    endfunction

    function automatic clip_res_t clip_segment(segment_t s);
        clip_res_t r;
        longint x1, y1, x2, y2, lx, ty, rx, by, dx, dy;
        longint n0, d0, n1, d1;
        bit vis;
        x1 = s.xs; y1 = s.ys; x2 = s.xe; y2 = s.ye;
        r = '{0, s.xs, s.ys, s.xe, s.ye};
        vis = 0;
        if (rect_w <= 0 || rect_h <= 0) return r;
        lx = rect_x;
        ty = rect_y;
        rx = clampl(longint'(rect_x) + rect_w - 1, -32768, 32767);
        by = clampl(longint'(rect_y) + rect_h - 1, -32768, 32767);
        if ((x1 < lx && x2 < lx) || (x1 > rx && x2 > rx) ||
            (y1 < ty && y2 < ty) || (y1 > by && y2 > by))
            return r;
        if (y1 == y2)
        begin
            x1 = clampl(x1, lx, rx);
            x2 = clampl(x2, lx, rx);
            vis = 1;
        end
        else if (x1 == x2)
        begin
            y1 = clampl(y1, ty, by);
            y2 = clampl(y2, ty, by);
            vis = 1;
        end
        else
        begin
            dx = x2 - x1;
            dy = y2 - y1;
            n0 = 0; d0 = 1; n1 = 1; d1 = 1;
            if (boundary(-dx, x1 - lx, n0, d0, n1, d1) &&
                boundary(dx, rx - x1, n0, d0, n1, d1) &&
                boundary(-dy, y1 - ty, n0, d0, n1, d1) &&
                boundary(dy, by - y1, n0, d0, n1, d1))
            begin
                x2 = lerp_trunc(x1, dx, n1, d1);
                y2 = lerp_trunc(y1, dy, n1, d1);
                x1 = lerp_trunc(x1, dx, n0, d0);
                y1 = lerp_trunc(y1, dy, n0, d0);
                vis = 1;
            end
        end
        if (vis) r = '{1, coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
        return r;
    endfunction

    task automatic write_reg(logic [lsrc_pkg::REG_IDX_BITS-1:0] idx, coord_t val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            lsrc_pkg::REG_CLIP_X: rect_x = val;
            lsrc_pkg::REG_CLIP_Y: rect_y = val;
            lsrc_pkg::REG_CLIP_W: rect_w = val;
            lsrc_pkg::REG_CLIP_H: rect_h = val;
            default: ;
        endcase
    endtask

    task automatic set_rect(coord_t rx, coord_t ry, coord_t rw, coord_t rh);
        write_reg(lsrc_pkg::REG_CLIP_X, rx);
        write_reg(lsrc_pkg::REG_CLIP_Y, ry);
        write_reg(lsrc_pkg::REG_CLIP_W, rw);
        write_reg(lsrc_pkg::REG_CLIP_H, rh);
    endtask

    task automatic drain;
        while (expected_clips.size() != 0) @(posedge clk);
        repeat (CB + 20) @(posedge clk);
    endtask

    // valid is raised here and lowered only before a gap or by the caller
    task automatic send_segment(segment_t s, logic typed, clip_res_t res);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        x_start <= s.xs; y_start <= s.ys; x_end <= s.xe; y_end <= s.ye;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (typed) expected_clips.push_back(res);
        else expected_clips.push_back(clip_segment(s));
    endtask

    function automatic coord_t rand_near(coord_t base, int span);
        return coord_t'(longint'(base) + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = (rect_w > 0 ? rect_w : 64) + 40;
        if (kind == 0)
            s = segment_t'({$urandom, $urandom});
        else
        begin
            s.xs = rand_near(rect_x + rect_w / 2, span);
            s.ys = rand_near(rect_y + rect_h / 2, span);
            s.xe = rand_near(rect_x + rect_w / 2, span);
            s.ye = rand_near(rect_y + rect_h / 2, span);
            if (kind == 1) s.ye = s.ys;
            if (kind == 2) s.xe = s.xs;
            if (kind == 3) s.xe = coord_t'($urandom);
        end
        return s;
    endfunction

    // result side: random stalls plus an optional long hold-off
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (150) @(posedge clk);
                hold_off = 0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        clip_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_clips.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_clips.pop_front();
                if (visible !== e.vis)
                begin
                    $error("visible exp %0d got %0d", e.vis, visible); errors++;
                end
                if (clipped_x_start !== e.xs)
                begin
                    $error("clipped_x_start exp %0d got %0d", e.xs, clipped_x_start);
                    errors++;
                end
                if (clipped_y_start !== e.ys)
                begin
                    $error("clipped_y_start exp %0d got %0d", e.ys, clipped_y_start);
                    errors++;
                end
                if (clipped_x_end !== e.xe)
                begin
                    $error("clipped_x_end exp %0d got %0d", e.xe, clipped_x_end);
                    errors++;
                end
                if (clipped_y_end !== e.ye)
                begin
                    $error("clipped_y_end exp %0d got %0d", e.ye, clipped_y_end);
                    errors++;
                end
            end
        end
    end

    stim_row_t directed[] = '{
        // reset rectangle is empty: echo
        '{'{16'sd5, 16'sd5, 16'sd9, 16'sd9}, 1, '{0, 16'sd5, 16'sd5, 16'sd9, 16'sd9}},
        '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1,
          '{0, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}}
    };

    // rows checked after the 0,0,100,50 rectangle is set
    stim_row_t rect_rows[] = '{
        // fully inside
        '{'{16'sd10, 16'sd10, 16'sd20, 16'sd30}, 1, '{1, 16'sd10, 16'sd10, 16'sd20, 16'sd30}},
        // wholly left
        '{'{-16'sd5, 16'sd3, -16'sd1, 16'sd40}, 1, '{0, -16'sd5, 16'sd3, -16'sd1, 16'sd40}},
        // wholly below
        '{'{16'sd3, 16'sd50, 16'sd70, 16'sd90}, 1, '{0, 16'sd3, 16'sd50, 16'sd70, 16'sd90}},
        // horizontal clamp
        '{'{-16'sd32768, 16'sd7, 16'sd32767, 16'sd7}, 1, '{1, 16'sd0, 16'sd7, 16'sd99, 16'sd7}},
        // vertical clamp
        '{'{16'sd4, 16'sd32767, 16'sd4, -16'sd32768}, 1, '{1, 16'sd4, 16'sd49, 16'sd4, 16'sd0}},
        // corner miss: rejected by the clip
        '{'{-16'sd10, 16'sd40, 16'sd20, 16'sd70}, 1, '{0, -16'sd10, 16'sd40, 16'sd20, 16'sd70}},
        '{'{-16'sd50, -16'sd20, 16'sd150, 16'sd80}, 0, '0},
        '{'{16'sd99, 16'sd49, 16'sd0, 16'sd0}, 0, '0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 0, '0},
        '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 0, '0},
        '{'{16'sd100, 16'sd25, 16'sd50, 16'sd25}, 0, '0}
    };

    initial
    begin
        int n;
        segment_t s;
        rst_n = 0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0;
        x_start = '0; y_start = '0; x_end = '0; y_end = '0;
        rect_x = 0; rect_y = 0; rect_w = 0; rect_h = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (directed[i]) send_segment(directed[i].seg, directed[i].typed, directed[i].res);
        in_valid <= 0;
        drain();
        set_rect(16'sd0, 16'sd0, 16'sd100, 16'sd50);
        foreach (rect_rows[i]) send_segment(rect_rows[i].seg, rect_rows[i].typed, rect_rows[i].res);
        in_valid <= 0;
        drain();
        // rectangle reaching past the coordinate range
        set_rect(16'sd32000, -16'sd32768, 16'sd32767, 16'sd32767);
        for (int i = 0; i < 8; i++) send_segment(rand_segment(), 0, '0);
        in_valid <= 0;
        drain();
        set_rect(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd10);
        for (int i = 0; i < 4; i++) send_segment(rand_segment(), 0, '0);
        in_valid <= 0;
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_rect(16'sd0, 16'sd0, 16'sd1, 16'sd1);
                1: set_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
                2: set_rect(16'sd32767, 16'sd32767, 16'sd1, 16'sd1);
                3: set_rect(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                            coord_t'($urandom));
                default: set_rect(coord_t'(int'($urandom_range(0, 400)) - 200),
                                  coord_t'(int'($urandom_range(0, 400)) - 200),
                                  coord_t'($urandom_range(1, 300)),
                                  coord_t'($urandom_range(1, 300)));
            endcase
            if (ph == 4) hold_off = 1;
            n = 100;
            for (int i = 0; i < n; i++)
            begin
                if (i == 50)
                begin
                    // pause until everything outstanding has come back
                    in_valid <= 0;
                    while (expected_clips.size() != 0) @(posedge clk);
                end
                s = rand_segment();
                send_segment(s, 0, '0);
            end
            in_valid <= 0;
            drain();
        end

        repeat (CB + 20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
